>>> design/threshold_sparsify_to_csr_top_defines.svh
// assertion macros for the threshold sparsifier checker
`ifndef THRESHOLD_SPARSIFY_TO_CSR_TOP_DEFINES_SVH
`define THRESHOLD_SPARSIFY_TO_CSR_TOP_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/tsc_pkg.sv
// shared types and constants for the threshold sparsifier
package tsc_pkg;
    localparam int unsigned COL_W   = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned TOT_W   = 48;
    localparam logic [CNT_W-1:0] MAX_COLUMNS = 17'h10000;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
    localparam logic [0:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [0:0] CFG_ROW_LENGTH = 1'b1;
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        first_of_matrix;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] column_index;
        logic [TOT_W-1:0] row_offset;
        logic [CNT_W-1:0] row_count;
        logic             last;
    } t_out;

    // ieee a >= b on float32 bit patterns, false on nan
    function automatic logic f_ge(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic r;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != '0);
        if (a_nan || b_nan) begin
            r = 1'b0;
        end else if ((a[30:0] == '0) && (b[30:0] == '0)) begin
            r = 1'b1;
        end else if (a[31] != b[31]) begin
            r = b[31];
        end else if (!a[31]) begin
            r = (a[30:0] >= b[30:0]);
        end else begin
            r = (a[30:0] <= b[30:0]);
        end
        return r;
    endfunction
endpackage

>>> design/threshold_sparsify_to_csr_top.sv
// top level of the threshold sparsifier, dense float32 rows to csr indices
// usage:
//   input channel i_valid / o_stall carries one dense element per request,
//   with a flag that starts a new matrix and clears column and totals.
//   output channel o_valid / i_stall carries column requests for kept
//   elements and a row-end request carrying the new offset and row count.
//   an element causes zero, one or two output requests; last marks the final.
//   latency: an element's first output appears the cycle after acceptance.
//   throughput: one element per cycle while each yields at most one output
//   and i_stall stays low; an element yielding two outputs holds the input
//   until the single output register has taken its second request.
//   stall: a full output stage with i_stall high raises o_stall at once; the
//   second pending output waits in a one-entry holding register.
//   reset: synchronous, active low; threshold +0.0, row length 1, counters
//   and totals zero, no output pending. configuration: i_cfg_we,
//   i_cfg_index, i_cfg_data: user must write only when idle; not enforced.
module threshold_sparsify_to_csr_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tsc_pkg::t_in      i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output tsc_pkg::t_out     o_data,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import tsc_pkg::*;

    logic [31:0]      r_thr;
    logic [CNT_W-1:0] r_len;
    logic [COL_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_kept, n_kept;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic             r_ov, n_ov;
    t_out             r_out, n_out;
    logic             r_hv, n_hv;
    t_out             r_hold, n_hold;

    logic             acc;
    logic             keep;
    logic             row_end;
    logic [CNT_W-1:0] eff_m1;
    logic [COL_W-1:0] col0;
    logic [CNT_W-1:0] kept0, kept1;
    logic [TOT_W-1:0] tot0, sum;
    logic             out_free;
    t_out             res_a, res_b;

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = r_hv || !out_free;
    assign acc      = i_valid && !o_stall;
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    always_comb begin
        priority if (r_len == '0) begin
            eff_m1 = '0;
        end else if (r_len > MAX_COLUMNS) begin
            eff_m1 = MAX_COLUMNS - 17'd1;
        end else begin
            eff_m1 = r_len - 17'd1;
        end
        col0  = i_data.first_of_matrix ? '0 : r_col;
        kept0 = i_data.first_of_matrix ? '0 : r_kept;
        tot0  = i_data.first_of_matrix ? '0 : r_tot;
        keep  = f_ge({1'b0, i_data.sample_bits[30:0]}, r_thr);
        kept1 = (keep && kept0 != COUNT_MAX) ? kept0 + 17'd1 : kept0;
        row_end = ({1'b0, col0} >= eff_m1);
        sum = tot0 + {{(TOT_W-CNT_W){1'b0}}, kept1};
        if (sum < tot0) begin
            sum = TOTAL_MAX;
        end
        res_a = '{kind: KIND_COLUMN, column_index: col0, row_offset: '0,
                  row_count: '0, last: !row_end};
        res_b = '{kind: KIND_ROW, column_index: '0, row_offset: sum,
                  row_count: kept1, last: 1'b1};

        n_col = r_col; n_kept = r_kept; n_tot = r_tot;
        n_ov = r_ov; n_out = r_out; n_hv = r_hv; n_hold = r_hold;
        if (out_free) begin
            n_ov = 1'b0;
            if (r_hv) begin
                n_ov = 1'b1; n_out = r_hold; n_hv = 1'b0;
            end
        end
        if (acc) begin
            n_col  = row_end ? '0 : col0 + 16'd1;
            n_kept = row_end ? '0 : kept1;
            n_tot  = row_end ? sum : tot0;
            if (keep) begin
                n_ov = 1'b1; n_out = res_a;
                if (row_end) begin
                    n_hv = 1'b1; n_hold = res_b;
                end
            end else if (row_end) begin
                n_ov = 1'b1; n_out = res_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0; r_len <= 17'd1;
            r_col <= '0; r_kept <= '0; r_tot <= '0;
            r_ov <= 1'b0; r_hv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD:  r_thr <= i_cfg_data;
                    CFG_ROW_LENGTH: r_len <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            r_col <= n_col; r_kept <= n_kept; r_tot <= n_tot;
            r_ov <= n_ov; r_hv <= n_hv;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
    end
endmodule

>>> design/tsc_checker.sv
// port-level assertion checker for the threshold sparsifier
`include "threshold_sparsify_to_csr_top_defines.svh"
module tsc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input tsc_pkg::t_out o_data
);
    import tsc_pkg::*;

    logic col_v;
    logic row_v;
    logic col_zero;
    logic row_ok;

    assign col_v    = o_valid && (o_data.kind == KIND_COLUMN);
    assign row_v    = o_valid && (o_data.kind == KIND_ROW);
    assign col_zero = (o_data.row_offset == '0) && (o_data.row_count == '0);
    assign row_ok   = o_data.last && (o_data.column_index == '0);

    `TSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `TSC_ASSERT_IMP(a_col_fields, i_clk, i_rst_n, col_v, col_zero)
    `TSC_ASSERT_IMP(a_row_last, i_clk, i_rst_n, row_v, row_ok)
    `TSC_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, o_valid)
endmodule

bind threshold_sparsify_to_csr_top tsc_checker u_tsc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

>>> dv/threshold_sparsify_to_csr_top_test.sv
// testbench for the threshold sparsifier: random and directed elements checked against a predictor
`timescale 1ns / 1ps

class csr_scoreboard;
    logic [31:0] threshold;
    logic [16:0] row_len;
    logic [15:0] column;
    logic [16:0] kept;
    logic [47:0] total;
    tsc_pkg::t_out pending_results[$];
    int errors;

    function void clear();
        threshold = '0;
        row_len = 17'd1;
        column = '0;
        kept = '0;
        total = '0;
        pending_results.delete();
        errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] value);
        if (idx == tsc_pkg::CFG_THRESHOLD) begin
            threshold = value;
        end else begin
            row_len = value[16:0];
        end
    endfunction

    function logic magnitude_kept(logic [31:0] s);
        logic [31:0] m;
        logic m_nan;
        logic t_nan;
        m = {1'b0, s[30:0]};
        m_nan = (m[30:23] == 8'hff) && (m[22:0] != '0);
        t_nan = (threshold[30:23] == 8'hff) && (threshold[22:0] != '0);
        if (m_nan || t_nan) return 1'b0;
        if (threshold[31]) return 1'b1;
        return m[30:0] >= threshold[30:0];
    endfunction

    function void note_request(tsc_pkg::t_in req);
        logic [16:0] len;
        tsc_pkg::t_out r;
        int n;
        n = 0;
        len = (row_len == 0) ? 17'd1 : (row_len > tsc_pkg::MAX_COLUMNS) ? tsc_pkg::MAX_COLUMNS
                                                                        : row_len;
        if (req.first_of_matrix) begin
            column = '0;
            kept = '0;
            total = '0;
        end
        if (magnitude_kept(req.sample_bits)) begin
            r = '0;
            r.kind = tsc_pkg::KIND_COLUMN;
            r.column_index = column;
            pending_results.push_back(r);
            n++;
            if (kept != tsc_pkg::COUNT_MAX) kept++;
        end
        if ({1'b0, column} >= len - 17'd1) begin
            if ({31'd0, kept} > tsc_pkg::TOTAL_MAX - total) begin
                total = tsc_pkg::TOTAL_MAX;
            end else begin
                total = total + {31'd0, kept};
            end
            r = '0;
            r.kind = tsc_pkg::KIND_ROW;
            r.row_offset = total;
            r.row_count = kept;
            pending_results.push_back(r);
            n++;
            column = '0;
            kept = '0;
        end else begin
            column++;
        end
        if (n > 0) pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(tsc_pkg::t_out got);
        tsc_pkg::t_out want;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.column_index !== want.column_index)
            report($sformatf("column %0d want %0d", got.column_index, want.column_index));
        if (got.row_offset !== want.row_offset)
            report($sformatf("offset %0d want %0d", got.row_offset, want.row_offset));
        if (got.row_count !== want.row_count)
            report($sformatf("count %0d want %0d", got.row_count, want.row_count));
        if (got.last !== want.last) report($sformatf("last %0d want %0d", got.last, want.last));
    endtask
endclass

module threshold_sparsify_to_csr_top_test;
    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    tsc_pkg::t_in i_data;
    logic o_valid;
    logic i_stall;
    tsc_pkg::t_out o_data;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    csr_scoreboard board;
    int idle_pct;
    int quiet_cycles;

    threshold_sparsify_to_csr_top dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        board = new();
        board.clear();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_pct = 19;
        quiet_cycles = 0;
    end

    // receiver: random stall, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) board.check_result(o_data);
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // watchdog on progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(logic [31:0] s, logic f);
        tsc_pkg::t_in req;
        req.sample_bits = s;
        req.first_of_matrix = f;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(req);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample(logic [31:0] thr);
        case ($urandom_range(9))
            0: return 32'h7fc00000 | $urandom_range(1, 32'h3fffff);
            1: return {1'($urandom_range(1)), 8'hff, 23'd0};
            2: return {1'($urandom_range(1)), 31'd0};
            3: return thr ^ {1'($urandom_range(1)), 31'd0};
            4: return thr + $urandom_range(2) - 1;
            default: return $urandom();
        endcase
    endfunction

    logic [31:0] thr_set[7] = '{32'h0, 32'h3f800000, 32'h80000000, 32'hbf800000,
                                32'h7f800000, 32'h7fc00001, 32'hffffffff};
    logic [31:0] len_set[8] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8,
                                32'h1ffff, 32'h10000};

    initial begin
        logic [31:0] thr;
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes, nan, infinities, signed zero
        send_request(32'h00000000, 1'b1);
        send_request(32'h80000000, 1'b0);
        send_request(32'hffffffff, 1'b0);
        send_request(32'h7f800000, 1'b0);
        send_request(32'h7fc00000, 1'b0);
        drain();
        write_reg(tsc_pkg::CFG_THRESHOLD, 32'h3f800000);
        write_reg(tsc_pkg::CFG_ROW_LENGTH, 32'd4);
        send_request(32'h3f800000, 1'b1);
        send_request(32'hbf800000, 1'b0);
        send_request(32'h3f7fffff, 1'b0);
        send_request(32'h7f7fffff, 1'b0);
        send_request(32'h3f800001, 1'b0);
        // row length shrunk mid-row
        drain();
        write_reg(tsc_pkg::CFG_ROW_LENGTH, 32'd2);
        send_request(32'h40000000, 1'b0);
        send_request(32'h40000000, 1'b0);
        drain();
        write_reg(tsc_pkg::CFG_THRESHOLD, 32'hbf800000);
        send_request(32'h7fc00001, 1'b0);
        send_request(32'h00000001, 1'b0);
        drain();
        write_reg(tsc_pkg::CFG_THRESHOLD, 32'h7fc00000);
        send_request(32'h7f800000, 1'b0);
        send_request(32'h00000000, 1'b0);

        for (int phase = 0; phase < 16; phase++) begin
            drain();
            thr = (phase % 3 == 2) ? $urandom() : thr_set[$urandom_range(6)];
            if (phase < 2) thr = 32'h80000000;
            len = len_set[$urandom_range(5)];
            if (phase == 3) len = 32'h1ffff;
            idle_pct = (phase == 5) ? 0 : 19;
            write_reg(tsc_pkg::CFG_THRESHOLD, thr);
            write_reg(tsc_pkg::CFG_ROW_LENGTH, len);
            for (int k = 0; k < 100; k++) begin
                send_request(pick_sample(thr), ($urandom_range(29) == 0) || k == 0);
            end
        end
        drain();
        idle_pct = 19;
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/tsc_pkg.sv
design/threshold_sparsify_to_csr_top.sv
design/tsc_checker.sv
dv/threshold_sparsify_to_csr_top_test.sv
